### rtl/atte_pkg.sv
// Shared types, constants and palette function for the ANSI text engine.
`timescale 1ns / 1ps
package atte_pkg;
	localparam int MAX_COLS = 128;
	localparam int MAX_ROWS = 64;
	localparam int MAX_ARGS = 16;
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int ARG_IW = $clog2(MAX_ARGS);

	localparam logic [1:0] KIND_CELL = 2'd0;
	localparam logic [1:0] KIND_FILL_ROW = 2'd1;
	localparam logic [1:0] KIND_FILL_SCREEN = 2'd2;
	localparam logic [1:0] KIND_SCROLL = 2'd3;

	localparam logic [1:0] REG_COLS = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;

	localparam logic [11:0] FG_RESET = 12'hfff;
	localparam logic [11:0] FG_TX = 12'h0f0;
	localparam logic [11:0] BG_RESET = 12'h000;
	localparam logic [7:0] SPACE = 8'h20;

	// queue entry between front and back
	typedef struct packed {
		logic [7:0] ch;
		logic [1:0] dir;
	} byte_t;

	function automatic logic [3:0] cube_lvl(input logic [2:0] k);
		logic [3:0] r;
		begin
			unique case (k)
				3'd0: r = 4'h0;
				3'd1: r = 4'h5;
				3'd2: r = 4'h8;
				3'd3: r = 4'ha;
				3'd4: r = 4'hd;
				default: r = 4'hf;
			endcase
			return r;
		end
	endfunction

	function automatic logic [11:0] palette(input logic [7:0] i);
		logic [11:0] r;
		logic [7:0] j;
		logic [7:0] r1;
		logic [2:0] a, b, c;
		logic [11:0] v;
		begin
			j = i - 8'd16;
			// 6x6x6 cube digits by compare chains
			a = 3'd0;
			for (int k = 1; k < 6; k++)
				if (j >= 8'(36 * k)) a = 3'(k);
			r1 = j - 8'd36 * {5'd0, a};
			b = 3'd0;
			for (int k = 1; k < 6; k++)
				if (r1 >= 8'(6 * k)) b = 3'(k);
			c = 3'(r1 - 8'd6 * {5'd0, b});
			v = (12'd8 + 12'd10 * {4'd0, i - 8'd232}) >> 4;
			if (i < 8'd16) begin
				unique case (i[3:0])
					4'd0: r = 12'h000; 4'd1: r = 12'hc00; 4'd2: r = 12'h0c0;
					4'd3: r = 12'hcc0; 4'd4: r = 12'h00e; 4'd5: r = 12'hc0c;
					4'd6: r = 12'h0cc; 4'd7: r = 12'heee; 4'd8: r = 12'h777;
					4'd9: r = 12'hf00; 4'd10: r = 12'h0f0; 4'd11: r = 12'hff0;
					4'd12: r = 12'h55f; 4'd13: r = 12'hf0f; 4'd14: r = 12'h0ff;
					default: r = 12'hfff;
				endcase
			end else if (i < 8'd232) begin
				r = {cube_lvl(a), cube_lvl(b), cube_lvl(c)};
			end else begin
				r = {v[3:0], v[3:0], v[3:0]};
			end
			return r;
		end
	endfunction

	function automatic logic [3:0] chan(input logic [15:0] v);
		return (v > 16'd255) ? 4'hf : v[7:4];
	endfunction
endpackage

### rtl/atte_front.sv
// Input side: accepts bytes and holds them in a short queue.
`timescale 1ns / 1ps
module atte_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      char_byte,
	input  logic [1:0]      direction,
	output logic            q_valid,
	output atte_pkg::byte_t q_data,
	input  logic            q_pop
);
	import atte_pkg::*;
	localparam int DEPTH = 4;
	byte_t mem_q [DEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == 3'(DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 3'd0);
	assign q_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= '{ch: char_byte, dir: direction};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (q_pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(q_pop);
		end
	end
endmodule

### rtl/atte_back.sv
// Execution side: parser, cursor, colors, SGR walk and result emission.
`timescale 1ns / 1ps
module atte_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  atte_pkg::byte_t q_data,
	output logic            q_pop,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [7:0]      cfg_data,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      kind,
	output logic [5:0]      phys_row,
	output logic [6:0]      column,
	output logic [31:0]     cell_word,
	output logic [5:0]      top_row,
	output logic            last
);
	import atte_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SGR   = 6'b000010,
		ST_EMIT  = 6'b000100,
		ST_WRAP  = 6'b001000,
		ST_EMIT2 = 6'b010000,
		ST_CFG   = 6'b100000
	} state_t;

	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_ESC = 2'd1;
	localparam logic [1:0] MODE_BODY = 2'd2;

	state_t st_q;
	logic [7:0] cols_q;
	logic [6:0] rows_q;
	logic [6:0] ccol_q;
	logic [5:0] crow_q;
	logic [11:0] fg_q, bg_q;
	logic [1:0] mode_q;
	logic [15:0] args_q [MAX_ARGS];
	logic [4:0] argc_q;
	logic sgr_seen_q;
	logic [5:0] top_q;
	logic [4:0] pos_q;
	logic pend2_q;
	logic take;

	logic [1:0] o_kind_q;
	logic [5:0] o_row_q;
	logic [6:0] o_col_q;
	logic [31:0] o_word_q;
	logic [5:0] o_top_q;
	logic o_last_q;
	logic o_valid_q;

	assign out_valid = o_valid_q;
	assign kind = o_kind_q;
	assign phys_row = o_row_q;
	assign column = o_col_q;
	assign cell_word = o_word_q;
	assign top_row = o_top_q;
	assign last = o_last_q;

	assign cfg_ready = (st_q == ST_IDLE) && !q_valid;
	// a queued byte is executed this cycle
	assign take = (st_q == ST_IDLE) && !(cfg_valid && cfg_ready) && q_valid && !q_pop
		&& !o_valid_q;

	function automatic logic [15:0] arg_at(input logic [15:0] a [MAX_ARGS],
		input logic [5:0] k);
		return (k < 6'(MAX_ARGS)) ? a[k[ARG_IW-1:0]] : 16'd0;
	endfunction

	// (top + row) mod rows, row <= rows
	function automatic logic [5:0] phys_of(input logic [5:0] top,
		input logic [6:0] row, input logic [6:0] rows);
		logic [7:0] s;
		begin
			s = {2'd0, top} + {1'b0, row};
			if (s >= {1'b0, rows}) s = s - {1'b0, rows};
			return s[5:0];
		end
	endfunction

	function automatic logic [6:0] p0c_lim(input logic [15:0] a, input logic [7:0] m1);
		logic [15:0] t;
		begin
			t = ((a == 16'd0) ? 16'd1 : a) - 16'd1;
			if (t > {8'd0, m1}) t = {8'd0, m1};
			return t[6:0];
		end
	endfunction

	function automatic logic [11:0] rgb_at(input logic [15:0] a [MAX_ARGS],
		input logic [4:0] p);
		return {chan(arg_at(a, {1'b0, p} + 6'd2)), chan(arg_at(a, {1'b0, p} + 6'd3)),
			chan(arg_at(a, {1'b0, p} + 6'd4))};
	endfunction

	// top below 64, rows 1..64: repeated subtract over 6 narrow steps
	function automatic logic [5:0] top_mod(input logic [5:0] t, input logic [6:0] r);
		logic [6:0] v;
		begin
			v = {1'b0, t};
			for (int s = 5; s >= 0; s--)
				if ({6'd0, v} >= ({6'd0, r} << s)) v = v - 7'({6'd0, r} << s);
			return v[5:0];
		end
	endfunction

	logic [7:0] ch;
	logic [15:0] a0, a1, sgr_a, sel, idx_a;
	logic [16:0] d0;
	logic [6:0] rows_m1;
	logic [7:0] cols_m1;
	logic [15:0] p0r, p1c;
	logic [15:0] dig;
	logic [19:0] dig_v;
	logic [ARG_IW-1:0] dig_k;
	logic [11:0] pal_a, pal_s;
	logic [7:0] cbyte;
	logic [31:0] wcell;

	always_comb begin
		ch = q_data.ch;
		a0 = args_q[0];
		a1 = args_q[1];
		d0 = (a0 == 16'd0) ? 17'd1 : {1'b0, a0};
		rows_m1 = rows_q - 7'd1;
		cols_m1 = cols_q - 8'd1;
		p0r = ((a0 == 16'd0) ? 16'd1 : a0) - 16'd1;
		if (p0r > {9'd0, rows_m1}) p0r = {9'd0, rows_m1};
		// second argument exists once the final is counted
		p1c = (argc_q >= 5'd1) ? (((a1 == 16'd0) ? 16'd1 : a1) - 16'd1) : 16'd0;
		if (p1c > {8'd0, cols_m1}) p1c = {8'd0, cols_m1};
		dig_k = (argc_q < 5'(MAX_ARGS)) ? argc_q[ARG_IW-1:0] : ARG_IW'(MAX_ARGS - 1);
		dig_v = {4'd0, args_q[dig_k]} * 20'd10 + {12'd0, ch - 8'h30};
		dig = (dig_v > 20'd65535) ? 16'hffff : dig_v[15:0];
		sgr_a = arg_at(args_q, {1'b0, pos_q});
		sel = arg_at(args_q, {1'b0, pos_q} + 6'd1);
		idx_a = arg_at(args_q, {1'b0, pos_q} + 6'd2);
		pal_a = palette(sgr_a[7:0] - 8'd30);
		pal_s = palette(idx_a[7:0]);
		cbyte = (ch < 8'd32 || ch >= 8'd127) ? 8'h3f : ch;
		wcell = {bg_q, fg_q, SPACE};
	end

	always_ff @(posedge clk) begin
		if (take && mode_q == MODE_BODY && ch >= 8'h30 && ch <= 8'h39)
			args_q[dig_k] <= dig;
		else if (take && mode_q == MODE_ESC && ch == 8'h5b)
			for (int i = 0; i < MAX_ARGS; i++) args_q[i] <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cols_q <= 8'd80;
			rows_q <= 7'd24;
			ccol_q <= '0;
			crow_q <= '0;
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
			mode_q <= MODE_PLAIN;
			argc_q <= '0;
			sgr_seen_q <= 1'b0;
			top_q <= '0;
			pos_q <= '0;
			pend2_q <= 1'b0;
			o_valid_q <= 1'b0;
			q_pop <= 1'b0;
		end else begin
			q_pop <= 1'b0;
			if (o_valid_q && !out_stall) o_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						if (cfg_index == REG_COLS) begin
							cols_q <= (cfg_data == 8'd0) ? 8'd1 :
								(cfg_data > 8'(MAX_COLS) ? 8'(MAX_COLS) : cfg_data);
							st_q <= ST_CFG;
						end else if (cfg_index == REG_ROWS) begin
							rows_q <= (cfg_data[6:0] == 7'd0) ? 7'd1 :
								(cfg_data[6:0] > 7'(MAX_ROWS) ? 7'(MAX_ROWS) : cfg_data[6:0]);
							st_q <= ST_CFG;
						end
					end else if (q_valid && !q_pop && !o_valid_q) begin
						q_pop <= 1'b1;
						if (mode_q == MODE_PLAIN) begin
							if (ch == 8'h0d) ccol_q <= '0;
							else if (ch == 8'h07) begin
							end else if (ch == 8'h08) begin
								if (ccol_q != 7'd0) ccol_q <= ccol_q - 7'd1;
							end else if (ch == 8'h0a) begin
								if ({1'b0, crow_q} != rows_m1) crow_q <= crow_q + 6'd1;
								else begin
									o_kind_q <= KIND_SCROLL;
									o_row_q <= phys_of(top_q, {1'b0, crow_q} + 7'd1, rows_q);
									o_col_q <= '0;
									o_word_q <= wcell;
									o_top_q <= phys_of(top_q, 7'd1, rows_q);
									top_q <= phys_of(top_q, 7'd1, rows_q);
									o_last_q <= 1'b1;
									o_valid_q <= 1'b1;
								end
							end else if (ch == 8'h1b) mode_q <= MODE_ESC;
							else begin
								o_kind_q <= KIND_CELL;
								o_row_q <= phys_of(top_q, {1'b0, crow_q}, rows_q);
								o_col_q <= ccol_q;
								o_word_q <= {bg_q, (!sgr_seen_q && q_data.dir == 2'd1) ? FG_TX :
									(!sgr_seen_q && q_data.dir == 2'd2) ? FG_RESET : fg_q, cbyte};
								if (!sgr_seen_q && q_data.dir == 2'd1) fg_q <= FG_TX;
								else if (!sgr_seen_q && q_data.dir == 2'd2) fg_q <= FG_RESET;
								o_top_q <= top_q;
								o_valid_q <= 1'b1;
								if ({1'b0, ccol_q} + 8'd1 >= cols_q) begin
									ccol_q <= '0;
									o_last_q <= ({1'b0, crow_q} != rows_m1);
									pend2_q <= ({1'b0, crow_q} == rows_m1);
									if ({1'b0, crow_q} != rows_m1) crow_q <= crow_q + 6'd1;
									st_q <= ST_WRAP;
								end else begin
									ccol_q <= ccol_q + 7'd1;
									o_last_q <= 1'b1;
								end
							end
						end else if (mode_q == MODE_ESC) begin
							if (ch == 8'h5b) begin
								mode_q <= MODE_BODY;
								argc_q <= '0;
							end else mode_q <= MODE_PLAIN;
						end else begin
							if (ch >= 8'h20 && ch <= 8'h3f) begin
								if (ch == 8'h3b && argc_q < 5'(MAX_ARGS - 1))
									argc_q <= argc_q + 5'd1;
							end else begin
								mode_q <= MODE_PLAIN;
								argc_q <= argc_q + 5'd1;
								unique case (ch)
									8'h41: crow_q <= (d0 > {11'd0, crow_q}) ? 6'd0 :
										crow_q - d0[5:0];
									8'h42: crow_q <= (d0 > {10'd0, rows_m1 - {1'b0, crow_q}}) ?
										rows_m1[5:0] : crow_q + d0[5:0];
									8'h43: ccol_q <= (d0 > {9'd0, cols_m1 - {1'b0, ccol_q}}) ?
										cols_m1[6:0] : ccol_q + d0[6:0];
									8'h44: ccol_q <= (d0 > {10'd0, ccol_q}) ? 7'd0 :
										ccol_q - d0[6:0];
									8'h47: ccol_q <= p0c_lim(a0, cols_m1);
									8'h48: begin
										crow_q <= p0r[5:0];
										ccol_q <= p1c[6:0];
									end
									8'h4a: if (a0 == 16'd2) begin
										o_kind_q <= KIND_FILL_SCREEN;
										o_row_q <= '0;
										o_col_q <= '0;
										o_word_q <= wcell;
										o_top_q <= top_q;
										o_last_q <= 1'b1;
										o_valid_q <= 1'b1;
										ccol_q <= '0;
										crow_q <= '0;
									end
									8'h4b: if (a0 == 16'd0) begin
										o_kind_q <= KIND_FILL_ROW;
										o_row_q <= phys_of(top_q, {1'b0, crow_q}, rows_q);
										o_col_q <= ccol_q;
										o_word_q <= wcell;
										o_top_q <= top_q;
										o_last_q <= 1'b1;
										o_valid_q <= 1'b1;
									end
									8'h6d: begin
										sgr_seen_q <= 1'b1;
										pos_q <= '0;
										st_q <= ST_SGR;
									end
									default: begin
									end
								endcase
							end
						end
					end
				end
				ST_SGR: begin
					// one argument group per cycle
					if (pos_q >= argc_q) st_q <= ST_IDLE;
					else begin
						pos_q <= pos_q + 5'd1;
						priority if (sgr_a == 16'd0) begin
							fg_q <= FG_RESET; bg_q <= BG_RESET;
						end else if (sgr_a == 16'd8) fg_q <= bg_q;
						else if (sgr_a >= 16'd30 && sgr_a <= 16'd37) fg_q <= pal_a;
						else if (sgr_a == 16'd38 || sgr_a == 16'd48) begin
							if (sel == 16'd5) begin
								if (sgr_a == 16'd38) fg_q <= pal_s; else bg_q <= pal_s;
								pos_q <= pos_q + 5'd3;
							end else if (sel == 16'd2) begin
								if (sgr_a == 16'd38) fg_q <= rgb_at(args_q, pos_q);
								else bg_q <= rgb_at(args_q, pos_q);
								pos_q <= pos_q + 5'd5;
							end else pos_q <= pos_q + 5'd2;
						end else if (sgr_a == 16'd39) fg_q <= FG_RESET;
						else if (sgr_a >= 16'd40 && sgr_a <= 16'd47)
							bg_q <= palette(sgr_a[7:0] - 8'd40);
						else if (sgr_a == 16'd49) bg_q <= BG_RESET;
						else if (sgr_a >= 16'd90 && sgr_a <= 16'd97)
							fg_q <= palette(sgr_a[7:0] - 8'd82);
						else if (sgr_a >= 16'd100 && sgr_a <= 16'd107)
							bg_q <= palette(sgr_a[7:0] - 8'd92);
						else begin
						end
					end
				end
				ST_WRAP: begin
					if (!pend2_q) st_q <= ST_IDLE;
					else if (!o_valid_q || !out_stall) begin
						o_kind_q <= KIND_SCROLL;
						o_row_q <= phys_of(top_q, {1'b0, crow_q} + 7'd1, rows_q);
						o_col_q <= '0;
						o_word_q <= wcell;
						o_top_q <= phys_of(top_q, 7'd1, rows_q);
						top_q <= phys_of(top_q, 7'd1, rows_q);
						o_last_q <= 1'b1;
						o_valid_q <= 1'b1;
						pend2_q <= 1'b0;
						st_q <= ST_EMIT2;
					end
				end
				ST_EMIT2: st_q <= ST_IDLE;
				ST_EMIT: st_q <= ST_IDLE;
				ST_CFG: begin
					if ({1'b0, ccol_q} > cols_m1) ccol_q <= cols_m1[6:0];
					if ({1'b0, crow_q} > rows_m1) crow_q <= rows_m1[5:0];
					top_q <= top_mod(top_q, rows_q);
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/ansi_terminal_text_engine_top.sv
// Top level of the ANSI text engine: byte queue in front of the executor.
`timescale 1ns / 1ps
// Takes one terminal byte per beat and emits up to two buffer commands per
// byte. The executor takes a byte only once the previous result has left the
// output register; a line wrap passes through a wrap state, and a wrap that
// scrolls waits for its first result to leave before the scroll command.
// An SGR final walks its stored arguments one group per cycle. A four-entry
// byte queue in front keeps input flowing while the executor or the output
// waits. Register writes are taken when the queue is empty and the
// executor idle.
module ansi_terminal_text_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic [1:0]  direction,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [5:0]  phys_row,
	output logic [6:0]  column,
	output logic [31:0] cell_word,
	output logic [5:0]  top_row,
	output logic        last
);
	import atte_pkg::*;
	logic q_valid, q_pop;
	byte_t q_data;

	atte_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .char_byte, .direction,
		.q_valid, .q_data, .q_pop
	);

	atte_back u_back (
		.clk, .arst_n, .q_valid, .q_data, .q_pop,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.out_valid, .out_stall, .kind, .phys_row, .column, .cell_word,
		.top_row, .last
	);
endmodule

### tb/sv/tb_ansi_terminal_text_engine_top.sv
// Self-checking testbench for the ANSI text engine: directed table, random streams, predictor.
`timescale 1ns / 1ps
module tb_ansi_terminal_text_engine_top;
	import atte_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  row;
		logic [6:0]  col;
		logic [31:0] word;
		logic [5:0]  top;
		logic        last;
	} cmd_t;

	typedef enum logic [1:0] {PM_PLAIN, PM_ESC, PM_BODY} pmode_t;

	// directed rows: byte, direction, typed-in first command (check only if chk)
	typedef struct packed {
		logic [7:0] ch;
		logic [1:0] dir;
		logic       chk;
		cmd_t       want;
	} row_t;

	localparam int LIMIT = 2000000;

	logic        clk, arst_n;
	logic        in_valid, cfg_valid, out_stall;
	logic [7:0]  char_byte, cfg_data;
	logic [1:0]  direction, cfg_index;
	logic        in_stall, cfg_ready, out_valid;
	logic [1:0]  kind;
	logic [5:0]  phys_row, top_row;
	logic [6:0]  column;
	logic [31:0] cell_word;
	logic        last;

	ansi_terminal_text_engine_top u_dut (.*);

	// predictor state
	int unsigned m_cols, m_rows, m_ccol, m_crow, m_top, m_argc;
	logic [11:0] m_fg, m_bg;
	pmode_t      m_mode;
	bit          m_sgr;
	int unsigned m_args[MAX_ARGS];

	cmd_t cmd_q[$];
	cmd_t typed_q[$];
	cmd_t step_out[$];
	int   errors, n_cmds, n_bytes;
	longint cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_ansi_terminal_text_engine_top: done, errors");
			$finish;
		end
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		errors++;
		$display("mismatch %s: got %0h expected %0h (cmd %0d)", what, got, exp, n_cmds);
	endtask

	function automatic logic [11:0] pal(input int unsigned idx);
		logic [11:0] b16[16] = '{12'h000, 12'hc00, 12'h0c0, 12'hcc0, 12'h00e, 12'hc0c,
			12'h0cc, 12'heee, 12'h777, 12'hf00, 12'h0f0, 12'hff0, 12'h55f, 12'hf0f,
			12'h0ff, 12'hfff};
		logic [3:0] lv[6] = '{4'h0, 4'h5, 4'h8, 4'ha, 4'hd, 4'hf};
		int unsigned i, j, v;
		i = idx & 255;
		if (i < 16) return b16[i];
		if (i < 232) begin
			j = i - 16;
			return {lv[j / 36], lv[(j / 6) % 6], lv[j % 6]};
		end
		v = (8 + 10 * (i - 232)) >> 4;
		return {v[3:0], v[3:0], v[3:0]};
	endfunction

	function automatic int unsigned arg_rd(input int unsigned k);
		return (k < MAX_ARGS) ? m_args[k] : 0;
	endfunction

	function automatic logic [3:0] chn(input int unsigned v);
		return (v > 255) ? 4'hf : v[7:4];
	endfunction

	function automatic logic [31:0] cellw(input logic [7:0] c);
		return {m_bg, m_fg, c};
	endfunction

	function automatic logic [5:0] prow(input int unsigned r);
		return 6'((m_top + r) % m_rows);
	endfunction

	function automatic void push_cmd(input logic [1:0] k, input logic [5:0] r,
			input logic [6:0] c, input logic [31:0] w);
		step_out.push_back('{kind: k, row: r, col: c, word: w, top: 6'(m_top), last: 1'b0});
	endfunction

	function automatic void next_line();
		logic [5:0] r;
		if (m_crow != m_rows - 1) m_crow++;
		else begin
			r = prow(m_crow + 1);
			m_top = (m_top + 1) % m_rows;
			push_cmd(KIND_SCROLL, r, 0, cellw(SPACE));
		end
	endfunction

	function automatic void run_sgr();
		int unsigned p, a, used, sel;
		logic [11:0] c;
		bit ok;
		m_sgr = 1;
		p = 0;
		while (p < m_argc) begin
			a = arg_rd(p);
			used = 1;
			if (a == 0) begin m_fg = FG_RESET; m_bg = BG_RESET; end
			else if (a == 8) m_fg = m_bg;
			else if (a >= 30 && a <= 37) m_fg = pal(a - 30);
			else if (a == 38 || a == 48) begin
				sel = arg_rd(p + 1);
				ok = 1;
				c = 0;
				if (sel == 5) begin c = pal(arg_rd(p + 2)); used = 3; end
				else if (sel == 2) begin
					c = {chn(arg_rd(p + 2)), chn(arg_rd(p + 3)), chn(arg_rd(p + 4))};
					used = 5;
				end else begin ok = 0; used = 2; end
				if (ok) begin
					if (a == 38) m_fg = c; else m_bg = c;
				end
			end else if (a == 39) m_fg = FG_RESET;
			else if (a >= 40 && a <= 47) m_bg = pal(a - 40);
			else if (a == 49) m_bg = BG_RESET;
			else if (a >= 90 && a <= 97) m_fg = pal(a - 82);
			else if (a >= 100 && a <= 107) m_bg = pal(a - 92);
			p += used;
		end
	endfunction

	function automatic int unsigned pos_of(input int unsigned k, input int unsigned lim);
		int unsigned a;
		a = (k < m_argc) ? arg_rd(k) : 1;
		if (a == 0) a = 1;
		a--;
		return (a > lim - 1) ? lim - 1 : a;
	endfunction

	function automatic void run_final(input logic [7:0] c);
		int unsigned d;
		m_argc++;
		d = (arg_rd(0) == 0) ? 1 : arg_rd(0);
		case (c)
			"A": m_crow = (d > m_crow) ? 0 : m_crow - d;
			"B": m_crow = (d > m_rows - 1 - m_crow) ? m_rows - 1 : m_crow + d;
			"C": m_ccol = (d > m_cols - 1 - m_ccol) ? m_cols - 1 : m_ccol + d;
			"D": m_ccol = (d > m_ccol) ? 0 : m_ccol - d;
			"G": m_ccol = pos_of(0, m_cols);
			"H": begin
				m_crow = pos_of(0, m_rows);
				m_ccol = (m_argc >= 2) ? pos_of(1, m_cols) : 0;
			end
			"J": if (arg_rd(0) == 2) begin
				push_cmd(KIND_FILL_SCREEN, 0, 0, cellw(SPACE));
				m_ccol = 0;
				m_crow = 0;
			end
			"K": if (arg_rd(0) == 0) push_cmd(KIND_FILL_ROW, prow(m_crow), 7'(m_ccol), cellw(SPACE));
			"m": run_sgr();
			default: ;
		endcase
		m_mode = PM_PLAIN;
	endfunction

	// advance the model by one byte; queues the commands it causes
	function automatic void predict_byte(input logic [7:0] chi, input logic [1:0] dir);
		logic [7:0] c;
		int unsigned k, v;
		c = chi;
		step_out.delete();
		if (m_mode == PM_PLAIN) begin
			if (c == 8'h0d) m_ccol = 0;
			else if (c == 8'h07) ;
			else if (c == 8'h08) begin if (m_ccol > 0) m_ccol--; end
			else if (c == 8'h0a) next_line();
			else if (c == 8'h1b) m_mode = PM_ESC;
			else begin
				if (c < 32 || c >= 127) c = "?";
				if (!m_sgr) begin
					if (dir == 1) m_fg = FG_TX;
					else if (dir == 2) m_fg = FG_RESET;
				end
				push_cmd(KIND_CELL, prow(m_crow), 7'(m_ccol), cellw(c));
				m_ccol++;
				if (m_ccol >= m_cols) begin m_ccol = 0; next_line(); end
			end
		end else if (m_mode == PM_ESC) begin
			if (c == "[") begin
				m_mode = PM_BODY;
				m_argc = 0;
				foreach (m_args[i]) m_args[i] = 0;
			end else m_mode = PM_PLAIN;
		end else begin
			if (c >= 8'h20 && c <= 8'h3f) begin
				if (c >= "0" && c <= "9") begin
					k = (m_argc < MAX_ARGS) ? m_argc : MAX_ARGS - 1;
					v = m_args[k] * 10 + (c - "0");
					m_args[k] = (v > 65535) ? 65535 : v;
				end else if (c == ";") begin
					if (m_argc < MAX_ARGS - 1) m_argc++;
				end
			end else run_final(c);
		end
		if (step_out.size() > 0) step_out[$].last = 1'b1;
		foreach (step_out[i]) cmd_q.push_back(step_out[i]);
	endfunction

	function automatic void predict_cfg(input logic [1:0] idx, input logic [7:0] val);
		if (idx == REG_COLS) m_cols = (val == 0) ? 1 : (val > MAX_COLS ? MAX_COLS : val);
		else if (idx == REG_ROWS) begin
			m_rows = (val[6:0] == 0) ? 1 : (val[6:0] > MAX_ROWS ? MAX_ROWS : val[6:0]);
		end else return;
		if (m_ccol > m_cols - 1) m_ccol = m_cols - 1;
		if (m_crow > m_rows - 1) m_crow = m_rows - 1;
		m_top = m_top % m_rows;
	endfunction

	// output side: random stall, compare each beat with oldest expectation
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				cmd_t e;
				n_cmds++;
				if (cmd_q.size() == 0) begin
					report("unexpected beat", {kind, phys_row, column}, 0);
				end else begin
					e = cmd_q.pop_front();
					if (kind != e.kind) report("kind", kind, e.kind);
					if (phys_row != e.row) report("phys_row", phys_row, e.row);
					if (column != e.col) report("column", column, e.col);
					if (cell_word != e.word) report("cell_word", cell_word, e.word);
					if (top_row != e.top) report("top_row", top_row, e.top);
					if (last != e.last) report("last", last, e.last);
					if (typed_q.size() > 0 && typed_q[0].last == 1'b0) begin
						// typed-in row expectation rides alongside the predictor
						void'(typed_q.pop_front());
					end else if (typed_q.size() > 0) begin
						if ({kind, phys_row, column, cell_word} !=
								{typed_q[0].kind, typed_q[0].row, typed_q[0].col, typed_q[0].word})
							report("directed row", cell_word, typed_q[0].word);
						void'(typed_q.pop_front());
					end
				end
			end
			case ($urandom_range(0, 19))
				0: out_stall <= 1'b1;
				1, 2, 3: out_stall <= ($urandom_range(0, 1) == 1);
				default: out_stall <= (out_stall && $urandom_range(0, 9) > 0 &&
					$urandom_range(0, 3) == 0);
			endcase
		end
	end

	// valid drops only ahead of a gap, so back-to-back beats keep it high
	task automatic send_byte(input logic [7:0] c, input logic [1:0] d);
		int gap;
		gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= c;
		direction <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_byte(c, d);
		n_bytes++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (cmd_q.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		predict_cfg(idx, val);
	endtask

	task automatic send_str(input string s, input logic [1:0] d);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], d);
	endtask

	function automatic string num(input int unsigned v);
		return $sformatf("%0d", v);
	endfunction

	// one random chunk: text run, line control, CSI sequence, broken escape or long SGR list
	task automatic random_chunk();
		int r, n;
		string s;
		logic [1:0] d;
		d = 2'($urandom_range(0, 3));
		r = $urandom_range(0, 99);
		if (r < 35) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)), d);
				else send_byte(8'($urandom_range(32, 126)), d);
			end
		end else if (r < 45) begin
			send_byte(($urandom_range(0, 1)) ? 8'h0a : 8'h0d, d);
			if ($urandom_range(0, 2) == 0) send_byte(8'h08, d);
		end else if (r < 85) begin
			case ($urandom_range(0, 9))
				0: s = {"\033[", num($urandom_range(0, 107)), "m"};
				1: s = {"\033[38;5;", num($urandom_range(0, 300)), "m"};
				2: s = {"\033[48;2;", num($urandom_range(0, 300)), ";",
					num($urandom_range(0, 300)), ";", num($urandom_range(0, 255)), "m"};
				3: s = {"\033[", num($urandom_range(0, 140)), ";",
					num($urandom_range(0, 140)), "H"};
				4: s = {"\033[", num($urandom_range(0, 140)), "G"};
				5: s = {"\033[", ($urandom_range(0, 3) == 0) ? "" : num($urandom_range(0, 70)),
					string'(8'($urandom_range(65, 68)))};
				6: s = {"\033[", num($urandom_range(0, 3)), "J"};
				7: s = {"\033[", num($urandom_range(0, 2)), "K"};
				8: s = {"\033[", num($urandom_range(0, 49)), ";", num($urandom_range(30, 107)),
					";38;", num($urandom_range(0, 7)), ";", num($urandom_range(0, 255)), "m"};
				default: s = {"\033[", num($urandom_range(0, 99999)), ";;",
					num($urandom_range(0, 9)), string'(8'($urandom_range(64, 126)))};
			endcase
			send_str(s, d);
		end else if (r < 95) begin
			// broken sequence: ESC then noise
			send_byte(8'h1b, d);
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), d);
		end else begin
			send_str("\033[", d);
			n = $urandom_range(10, 20);
			for (int i = 0; i < n; i++) begin
				send_str(num($urandom_range(0, 9)), d);
				send_byte(";", d);
			end
			send_byte("m", d);
		end
	endtask

	row_t dir_tab[$];

	initial begin
		cmd_t w;
		errors = 0; n_cmds = 0; n_bytes = 0;
		in_valid = 1'b0; cfg_valid = 1'b0; char_byte = '0; direction = '0;
		cfg_index = '0; cfg_data = '0;
		m_cols = 80; m_rows = 24; m_ccol = 0; m_crow = 0; m_top = 0; m_argc = 0;
		m_fg = FG_RESET; m_bg = BG_RESET; m_mode = PM_PLAIN; m_sgr = 0;
		foreach (m_args[i]) m_args[i] = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed expectations where obvious from reset state
		w = '{KIND_CELL, 6'd0, 7'd0, 32'h0000f041, 6'd0, 1'b1};
		dir_tab.push_back('{"A", 2'd1, 1'b1, w});
		w = '{KIND_CELL, 6'd0, 7'd1, 32'h000fff3f, 6'd0, 1'b1};
		dir_tab.push_back('{8'hff, 2'd2, 1'b1, w});
		w = '{KIND_CELL, 6'd0, 7'd2, 32'h000fff3f, 6'd0, 1'b1};
		dir_tab.push_back('{8'h00, 2'd0, 1'b1, w});
		dir_tab.push_back('{8'h7e, 2'd3, 1'b0, w});
		dir_tab.push_back('{8'h07, 2'd0, 1'b0, w});
		dir_tab.push_back('{8'h08, 2'd0, 1'b0, w});
		dir_tab.push_back('{8'h0d, 2'd0, 1'b0, w});
		dir_tab.push_back('{8'h0a, 2'd0, 1'b0, w});
		dir_tab.push_back('{8'h1b, 2'd0, 1'b0, w});
		dir_tab.push_back('{"x", 2'd0, 1'b0, w});
		dir_tab.push_back('{8'h1b, 2'd0, 1'b0, w});
		dir_tab.push_back('{"[", 2'd0, 1'b0, w});
		dir_tab.push_back('{"2", 2'd0, 1'b0, w});
		w = '{KIND_FILL_SCREEN, 6'd0, 7'd0, 32'h000fff20, 6'd0, 1'b1};
		dir_tab.push_back('{"J", 2'd0, 1'b1, w});
		dir_tab.push_back('{8'h1b, 2'd0, 1'b0, w});
		dir_tab.push_back('{"[", 2'd0, 1'b0, w});
		w = '{KIND_FILL_ROW, 6'd0, 7'd0, 32'h000fff20, 6'd0, 1'b1};
		dir_tab.push_back('{"K", 2'd0, 1'b1, w});
		foreach (dir_tab[i]) begin
			if (dir_tab[i].chk) begin
				// earlier beats leave first, so the next beat belongs to this row
				in_valid <= 1'b0;
				while (cmd_q.size() > 0) @(posedge clk);
				@(posedge clk);
				dir_tab[i].want.last = 1'b1;
				typed_q.push_back(dir_tab[i].want);
			end
			send_byte(dir_tab[i].ch, dir_tab[i].dir);
		end
		send_str("\033[99999999;38;2;300;16;255;48;5;999;38;9m*", 2'd1);
		send_str("\033[9;9;9;9;9;9;9;9;9;9;9;9;9;9;9;9;9;9;44m\033[0;1;2z#", 2'd2);

		// configuration phases, extremes included
		write_reg(REG_COLS, 8'd1);
		write_reg(REG_ROWS, 8'd1);
		repeat (20) random_chunk();
		write_reg(REG_COLS, 8'd0);
		write_reg(REG_ROWS, 8'd0);
		repeat (20) random_chunk();
		write_reg(REG_COLS, 8'd255);
		write_reg(REG_ROWS, 8'd255);
		repeat (60) random_chunk();
		write_reg(REG_COLS, 8'd128);
		write_reg(REG_ROWS, 8'd64);
		while (n_bytes < 500) random_chunk();
		// hold off until the block has caught up
		drain();
		write_reg(REG_COLS, 8'd3);
		write_reg(REG_ROWS, 8'd2);
		while (n_bytes < 900) random_chunk();
		write_reg(REG_COLS, 8'($urandom_range(1, 128)));
		write_reg(REG_ROWS, 8'($urandom_range(1, 64)));
		while (n_bytes < 1400) random_chunk();
		write_reg(REG_COLS, 8'd80);
		write_reg(REG_ROWS, 8'd24);
		while (n_bytes < 1770) random_chunk();

		drain();
		if (cmd_q.size() > 0) errors++;
		$display("covered %0d bytes, %0d buffer commands, register extremes and several sizes",
			n_bytes, n_cmds);
		if (errors == 0) $display("tb_ansi_terminal_text_engine_top: done, clean");
		else $display("tb_ansi_terminal_text_engine_top: done, errors");
		$finish;
	end
endmodule

### ansi_terminal_text_engine_top.f
rtl/atte_pkg.sv
rtl/atte_front.sv
rtl/atte_back.sv
rtl/ansi_terminal_text_engine_top.sv
tb/sv/tb_ansi_terminal_text_engine_top.sv
